FILE: rtl/core/cllm_pkg.sv
// Shared types and constants for the circular linked list manager.
// No dependencies.
package cllm_pkg;

    localparam int POOL_ENTRIES = 256;
    localparam int HW = 8;
    localparam int AW = $clog2(POOL_ENTRIES);
    localparam int QDEPTH = 2;

    typedef enum logic [2:0] {
        OP_PEEK = 3'd0, OP_PUSH_L = 3'd1, OP_PUSH_R = 3'd2, OP_POP_L = 3'd3,
        OP_POP_R = 3'd4, OP_INS_A = 3'd5, OP_INS_B = 3'd6, OP_REMOVE = 3'd7
    } t_op;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_MISUSE = 2'd2;

    // classified command handed from front to back
    typedef enum logic [2:0] {
        K_NOP, K_PUSH, K_POP, K_INSERT, K_REMOVE
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        left;     // push left / insert before / pop left
        logic [HW-1:0] node;
        logic [HW-1:0] key;
        logic        use_key;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_WAIT, S_WR1, S_WR2, S_DONE
    } t_state;

endpackage

FILE: rtl/core/circular_linked_list_manager_unit.sv
// Top level of the circular doubly linked list manager.
// Depends on cllm_pkg, cllm_front, cllm_back.
//
// One circular doubly linked list over 256 entry handles. Each input transaction
// carries one operation and yields exactly one result transaction. The back-end
// sequencer takes one operation at a time: peek, misuse, empty pop and first push
// go from its check straight to the result, while link-changing operations also
// fetch neighbor links once and write them in states WR1 and WR2. A two-entry
// command queue lets the front accept while the back works. No clearing pass:
// link stores are only read for linked entries, whose flags reset clears.
module circular_linked_list_manager_unit import cllm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[2:0], node[10:3], key[18:11], key_given[19], zero pad [23:20]
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], taken_node[9:2], taken_valid[10], first_entry[18:11],
    // last_entry[26:19], list_empty[27], zero pad [31:28]
    output logic [31:0] m_axis_tdata
);
    logic w_cv, w_cr;
    t_cmd w_cmd;
    logic [27:0] w_od;

    cllm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_operation(s_axis_tdata[2:0]), .i_node(s_axis_tdata[10:3]),
        .i_key(s_axis_tdata[18:11]), .i_key_given(s_axis_tdata[19]),
        .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd)
    );

    cllm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cv), .o_cmd_ready(w_cr), .i_cmd(w_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(w_od)
    );

    // back end already packs status, taken_node, taken_valid, first, last, empty
    assign m_axis_tdata = {4'd0, w_od};

`ifndef SYNTH
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[27] |-> m_axis_tdata[26:11] == 16'd0)
        else $error("empty list reports nonzero head/tail");
    a_taken_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[1:0] == ST_OK)
        else $error("pop result with bad status");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
`endif
endmodule

FILE: rtl/core/cllm_front.sv
// Front end: accepts operations and classifies them into commands.
// Depends on cllm_pkg.
module cllm_front import cllm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_operation,
    input  logic [HW-1:0] i_node,
    input  logic [HW-1:0] i_key,
    input  logic       i_key_given,
    output logic       o_cmd_valid,
    input  logic       i_cmd_ready,
    output t_cmd       o_cmd
);
    t_cmd r_q [QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd w_cmd;
    logic w_push, w_pop;

    always_comb begin
        w_cmd.node = i_node;
        w_cmd.key = i_key;
        w_cmd.use_key = 1'b0;
        w_cmd.left = 1'b0;
        w_cmd.kind = K_NOP;
        unique case (t_op'(i_operation))
            OP_PEEK: w_cmd.kind = K_NOP;
            OP_PUSH_L: begin w_cmd.kind = K_PUSH; w_cmd.left = 1'b1; end
            OP_PUSH_R: w_cmd.kind = K_PUSH;
            OP_POP_L: begin w_cmd.kind = K_POP; w_cmd.left = 1'b1; end
            OP_POP_R: w_cmd.kind = K_POP;
            OP_INS_A: begin
                w_cmd.kind = i_key_given ? K_INSERT : K_PUSH;
                w_cmd.use_key = i_key_given;
            end
            OP_INS_B: begin
                w_cmd.kind = i_key_given ? K_INSERT : K_PUSH;
                w_cmd.use_key = i_key_given;
                w_cmd.left = 1'b1;
            end
            OP_REMOVE: w_cmd.kind = K_REMOVE;
            default: w_cmd.kind = K_NOP;
        endcase
    end

    assign o_ready = (r_cnt != 2'(QDEPTH));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

FILE: rtl/core/cllm_back.sv
// Back end: link memories, linked flags, head/tail and the update sequencer.
// Depends on cllm_pkg.
module cllm_back import cllm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    output logic       o_cmd_ready,
    input  t_cmd       i_cmd,
    output logic       o_valid,
    input  logic       i_ready,
    // {empty, last, first, taken_valid, taken, status} from the top bit down
    output logic [27:0] o_data
);
    logic [HW-1:0] r_fwd [POOL_ENTRIES];
    logic [HW-1:0] r_bwd [POOL_ENTRIES];
    logic [POOL_ENTRIES-1:0] r_lnk;
    logic [HW-1:0] r_head, r_tail;
    logic r_empty;

    t_state r_st, n_st;
    t_cmd r_c;
    logic [HW-1:0] r_tgt;                // node unlinked by pop/remove
    logic [HW-1:0] r_fa, r_ba;           // forward/backward link read data
    logic [AW-1:0] r_ra;                 // read address
    logic [1:0] r_status;
    logic r_tv;
    logic [HW-1:0] r_taken;
    logic r_ov;
    logic [27:0] r_od;

    // write port controls
    logic w_fwe, w_bwe;
    logic [AW-1:0] w_fa, w_ba;
    logic [HW-1:0] w_fd, w_bd;

    logic w_node_in, w_key_in, w_node_lnk, w_key_lnk;
    assign w_node_in = ({{(32-HW){1'b0}}, r_c.node} < 32'(POOL_ENTRIES));
    assign w_key_in = ({{(32-HW){1'b0}}, r_c.key} < 32'(POOL_ENTRIES));
    assign w_node_lnk = w_node_in && r_lnk[r_c.node[AW-1:0]];
    assign w_key_lnk = w_key_in && r_lnk[r_c.key[AW-1:0]];

    assign o_cmd_ready = (r_st == S_IDLE);
    assign o_valid = r_ov;
    assign o_data = r_od;

    // sequence: IDLE takes cmd; RD checks, sets the link read address and links a first
    // push; WAIT gathers the links; WR1/WR2 write neighbor links; DONE registers the result
    logic w_bad, w_single;
    always_comb begin
        w_bad = 1'b0;
        unique case (r_c.kind)
            K_PUSH: w_bad = !w_node_in || w_node_lnk;
            K_INSERT: w_bad = !w_node_in || w_node_lnk || !w_key_lnk;
            K_REMOVE: w_bad = !w_node_lnk;
            K_POP: w_bad = 1'b0;
            default: w_bad = 1'b0;
        endcase
        w_single = (r_fa == r_tgt);
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_cmd_valid) n_st = S_RD;
            S_RD: begin
                if (r_c.kind == K_NOP || w_bad || (r_c.kind == K_POP && r_empty))
                    n_st = S_DONE;
                else if (r_c.kind == K_PUSH && r_empty) n_st = S_DONE;
                else n_st = S_WAIT;
            end
            S_WAIT: n_st = S_WR1;
            S_WR1: n_st = S_WR2;
            S_WR2: n_st = S_DONE;
            S_DONE: if (!r_ov || i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // link write controls per state
    always_comb begin
        w_fwe = 1'b0; w_bwe = 1'b0;
        w_fa = r_c.node[AW-1:0]; w_ba = r_c.node[AW-1:0];
        w_fd = r_c.node; w_bd = r_c.node;
        unique case (r_st)
            S_RD: if (r_c.kind == K_PUSH && r_empty && !w_bad) begin
                w_fwe = 1'b1; w_bwe = 1'b1;
            end
            S_WR1: begin
                if (r_c.kind == K_PUSH || r_c.kind == K_INSERT) begin
                    // r_ba = a (predecessor), r_fa = b (successor)
                    w_fwe = 1'b1; w_fa = r_ba[AW-1:0]; w_fd = r_c.node;
                    w_bwe = 1'b1; w_ba = r_fa[AW-1:0]; w_bd = r_c.node;
                end else if (!w_single) begin
                    w_bwe = 1'b1; w_ba = r_fa[AW-1:0]; w_bd = r_ba;
                    w_fwe = 1'b1; w_fa = r_ba[AW-1:0]; w_fd = r_fa;
                end
            end
            S_WR2: begin
                if (r_c.kind == K_PUSH || r_c.kind == K_INSERT) begin
                    w_fwe = 1'b1; w_fd = r_fa;
                    w_bwe = 1'b1; w_bd = r_ba;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_fwe) r_fwd[w_fa] <= w_fd;
        if (w_bwe) r_bwd[w_ba] <= w_bd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_lnk <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_empty <= 1'b1;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_DONE && (!r_ov || i_ready)) r_ov <= 1'b1;
            else if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_cmd_valid) begin
                    r_c <= i_cmd;
                    r_status <= ST_OK;
                    r_tv <= 1'b0;
                    r_taken <= '0;
                end
                S_RD: begin
                    if (w_bad) r_status <= ST_MISUSE;
                    else unique case (r_c.kind)
                        K_PUSH: begin
                            r_ra <= r_tail[AW-1:0];
                            if (r_empty) begin
                                r_lnk[r_c.node[AW-1:0]] <= 1'b1;
                                r_head <= r_c.node; r_tail <= r_c.node;
                                r_empty <= 1'b0;
                            end
                        end
                        K_INSERT: r_ra <= r_c.key[AW-1:0];
                        K_POP: begin
                            if (r_empty) r_status <= ST_EMPTY;
                            else begin
                                r_tgt <= r_c.left ? r_head : r_tail;
                                r_ra <= r_c.left ? r_head[AW-1:0] : r_tail[AW-1:0];
                                r_taken <= r_c.left ? r_head : r_tail;
                                r_tv <= 1'b1;
                            end
                        end
                        K_REMOVE: begin
                            r_tgt <= r_c.node; r_ra <= r_c.node[AW-1:0];
                        end
                        default: ;
                    endcase
                end
                S_WAIT: begin
                    // read links and arrange them as (pred, succ) for link ops
                    if (r_c.kind == K_PUSH) begin
                        r_ba <= r_tail; r_fa <= r_head;
                    end else if (r_c.kind == K_INSERT) begin
                        if (r_c.left) begin
                            r_fa <= r_c.key; r_ba <= r_bwd[r_ra];
                        end else begin
                            r_ba <= r_c.key; r_fa <= r_fwd[r_ra];
                        end
                    end else begin
                        r_fa <= r_fwd[r_ra]; r_ba <= r_bwd[r_ra];
                    end
                end
                S_WR1: begin
                    if (r_c.kind == K_PUSH || r_c.kind == K_INSERT) begin
                        r_lnk[r_c.node[AW-1:0]] <= 1'b1;
                        if (r_c.kind == K_PUSH) begin
                            if (r_c.left) r_head <= r_c.node;
                            else r_tail <= r_c.node;
                        end else if (!r_c.left && r_c.key == r_tail) r_tail <= r_c.node;
                        else if (r_c.left && r_c.key == r_head) r_head <= r_c.node;
                    end else begin
                        r_lnk[r_tgt[AW-1:0]] <= 1'b0;
                        if (w_single) begin
                            r_head <= '0; r_tail <= '0; r_empty <= 1'b1;
                        end else if (r_head == r_tgt) r_head <= r_fa;
                        else if (r_tail == r_tgt) r_tail <= r_ba;
                    end
                end
                S_DONE: if (!r_ov || i_ready) begin
                    r_od <= {r_empty, r_empty ? 8'd0 : r_tail,
                             r_empty ? 8'd0 : r_head, r_tv, r_taken, r_status};
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: dv/circular_linked_list_manager_unit_test.sv
// Testbench for circular_linked_list_manager_unit: directed and random list operations.
// Depends on cllm_pkg and the RTL of the unit; self-checking against an in-bench list model.
module circular_linked_list_manager_unit_test;
    import cllm_pkg::*;

    // Result transaction fields, as packed on m_axis_tdata from bit 0 up.
    typedef struct {
        logic [1:0] status;
        logic [7:0] taken;
        logic       taken_valid;
        logic [7:0] first;
        logic [7:0] last;
        logic       empty;
    } t_list_result;

    // Scoreboard: keeps a shadow of the link stores and checks each result transaction.
    class t_list_scoreboard;
        logic [7:0] fwd [256];
        logic [7:0] bwd [256];
        bit         linked [256];
        logic [7:0] head, tail;
        bit         empty;
        t_list_result pending_results[$];
        int         errors, checked, ops_seen[8];

        function new();
            foreach (linked[i]) begin
                linked[i] = 0;
                fwd[i] = '0;
                bwd[i] = '0;
            end
            head = '0;
            tail = '0;
            empty = 1;
            errors = 0;
            checked = 0;
        endfunction

        function void splice(logic [7:0] h, logic [7:0] a, logic [7:0] b);
            fwd[a] = h;
            bwd[b] = h;
            bwd[h] = a;
            fwd[h] = b;
            linked[h] = 1;
        endfunction

        function logic [1:0] push(logic [7:0] h, bit left);
            if (linked[h]) return ST_MISUSE;
            if (empty) begin
                fwd[h] = h;
                bwd[h] = h;
                linked[h] = 1;
                head = h;
                tail = h;
                empty = 0;
            end else begin
                splice(h, tail, head);
                if (left) head = h;
                else tail = h;
            end
            return ST_OK;
        endfunction

        function void unlink(logic [7:0] h);
            logic [7:0] nx, pv;
            nx = fwd[h];
            pv = bwd[h];
            if (nx == h) begin
                head = '0;
                tail = '0;
                empty = 1;
            end else begin
                bwd[nx] = pv;
                fwd[pv] = nx;
                if (head == h) head = nx;
                else if (tail == h) tail = pv;
            end
            fwd[h] = '0;
            bwd[h] = '0;
            linked[h] = 0;
        endfunction

        // Accepted input transaction: advance the shadow list and queue the expected result.
        function void note_operation(logic [23:0] d);
            t_op          op;
            logic [7:0]   node, key;
            bit           key_given;
            t_list_result r;
            op = t_op'(d[2:0]);
            node = d[10:3];
            key = d[18:11];
            key_given = d[19];
            ops_seen[d[2:0]]++;
            r.status = ST_OK;
            r.taken = '0;
            r.taken_valid = 0;
            case (op)
                OP_PUSH_L: r.status = push(node, 1);
                OP_PUSH_R: r.status = push(node, 0);
                OP_POP_L, OP_POP_R: begin
                    if (empty) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.taken = (op == OP_POP_L) ? head : tail;
                        r.taken_valid = 1;
                        unlink(r.taken);
                    end
                end
                OP_INS_A, OP_INS_B: begin
                    if (!key_given) begin
                        r.status = push(node, op == OP_INS_B);
                    end else if (linked[node] || !linked[key]) begin
                        r.status = ST_MISUSE;
                    end else if (op == OP_INS_A) begin
                        splice(node, key, fwd[key]);
                        if (key == tail) tail = node;
                    end else begin
                        splice(node, bwd[key], key);
                        if (key == head) head = node;
                    end
                end
                OP_REMOVE: begin
                    if (!linked[node]) r.status = ST_MISUSE;
                    else unlink(node);
                end
                default: ;
            endcase
            r.first = empty ? 8'd0 : head;
            r.last = empty ? 8'd0 : tail;
            r.empty = empty;
            pending_results.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h",
                     checked, what, got, want);
            errors++;
        endtask

        task check_result(logic [31:0] d);
            t_list_result e;
            if (pending_results.size() == 0) begin
                $display("MISMATCH unexpected result transaction 0x%0h", d);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (d[1:0] !== e.status)
                report("status", 32'(d[1:0]), 32'(e.status));
            if (d[9:2] !== e.taken)
                report("taken_node", 32'(d[9:2]), 32'(e.taken));
            if (d[10] !== e.taken_valid)
                report("taken_valid", 32'(d[10]), 32'(e.taken_valid));
            if (d[18:11] !== e.first)
                report("first_entry", 32'(d[18:11]), 32'(e.first));
            if (d[26:19] !== e.last)
                report("last_entry", 32'(d[26:19]), 32'(e.last));
            if (d[27] !== e.empty)
                report("list_empty", 32'(d[27]), 32'(e.empty));
            checked++;
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // operation, node, key, key_given from bit 0 up
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // status, taken_node, taken_valid, first, last, empty

    circular_linked_list_manager_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    t_list_scoreboard sb = new();
    int  idle_cycles = 0;
    int  burst_left = 0;
    bit  stim_done = 0;
    localparam int IDLE_LIMIT = 3000;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Monitor: both handshakes are sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_operation(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Receiver stall pattern: long ready stretches, occasional stall runs.
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 6);
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= 1;
        end
    end

    // Drive one transaction; sender works in random bursts with random gaps.
    task send(t_op op, logic [7:0] node, logic [7:0] key, bit key_given);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(0, 5)) begin
                s_axis_tvalid <= 0;
                @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1;
        s_axis_tdata <= {4'd0, key_given, key, node, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Pick a linked handle if there is one, else anything.
    function logic [7:0] some_linked();
        logic [7:0] h;
        int k;
        if (sb.empty) return 8'($urandom_range(0, 255));
        h = sb.head;
        k = $urandom_range(0, 15);
        repeat (k) h = sb.fwd[h];
        return h;
    endfunction

    task random_op();
        t_op        op;
        logic [7:0] node, key;
        bit         key_given;
        op = t_op'($urandom_range(0, 7));
        // small handle pool keeps collisions frequent; full range now and then
        node = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 23));
        key_given = ($urandom_range(0, 4) != 0);
        key = ($urandom_range(0, 5) != 0) ? some_linked() : 8'($urandom_range(0, 255));
        if (op == OP_REMOVE && $urandom_range(0, 3) != 0) node = some_linked();
        send(op, node, key, key_given);
    endtask

    initial begin
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: empty-list cases, extreme handles, misuse, key fallback
        send(OP_PEEK, 8'd0, 8'd0, 0);
        send(OP_POP_L, 8'd0, 8'd0, 0);
        send(OP_POP_R, 8'd0, 8'd0, 0);
        send(OP_REMOVE, 8'd5, 8'd0, 0);
        send(OP_PUSH_L, 8'd0, 8'd0, 0);
        send(OP_PUSH_R, 8'd255, 8'd0, 0);
        send(OP_PUSH_L, 8'd0, 8'd0, 0);
        send(OP_INS_A, 8'd7, 8'd99, 1);
        send(OP_INS_A, 8'd255, 8'd0, 1);
        send(OP_INS_A, 8'd170, 8'd255, 1);
        send(OP_INS_B, 8'd85, 8'd0, 1);
        send(OP_INS_B, 8'd1, 8'd255, 1);
        send(OP_INS_A, 8'd2, 8'hFF, 0);
        send(OP_INS_B, 8'd3, 8'hFF, 0);
        send(OP_PEEK, 8'hFF, 8'hFF, 1);
        send(OP_REMOVE, 8'd85, 8'd0, 0);
        send(OP_REMOVE, 8'd3, 8'd0, 0);
        send(OP_REMOVE, 8'd2, 8'd0, 0);
        send(OP_POP_L, 8'd0, 8'd0, 0);
        send(OP_POP_R, 8'd0, 8'd0, 0);
        send(OP_REMOVE, 8'd255, 8'd0, 0);
        send(OP_POP_L, 8'd0, 8'd0, 0);
        send(OP_POP_L, 8'd0, 8'd0, 0);
        send(OP_REMOVE, 8'd0, 8'd0, 0);

        for (int n = 0; n < 500; n++) begin
            random_op();
            if (n == 250) begin
                // hold off until every outstanding result has drained
                s_axis_tvalid <= 0;
                while (sb.pending_results.size() != 0) @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 0;
        stim_done = 1;

        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("checked %0d results; ops peek..remove: %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.checked, sb.ops_seen[0], sb.ops_seen[1], sb.ops_seen[2],
                 sb.ops_seen[3], sb.ops_seen[4], sb.ops_seen[5], sb.ops_seen[6],
                 sb.ops_seen[7]);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
